// File: rtl/imhu_pkg.sv
// shared types and constants for the indexed min-heap update block
package imhu_pkg;

  localparam int CAPACITY    = 1024;
  localparam int HANDLE_BITS = 16;
  localparam int POS_BITS    = 10;
  localparam int SIZE_BITS   = 11;
  localparam int KEY_BITS    = 64;
  localparam int CHILD_BITS  = POS_BITS + 2;
  localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;

  typedef struct packed {
    logic [POS_BITS-1:0]    position;
    logic [SIZE_BITS-1:0]   heap_size;
    logic [KEY_BITS-1:0]    entry_key;
    logic [HANDLE_BITS-1:0] entry_handle;
  } in_word_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] moved_handle;
    logic [POS_BITS-1:0]    new_position;
    logic                   last_move;
    logic                   bad_request;
  } out_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

endpackage

// File: rtl/imhu_ram.sv
// generic single-write, single-read ram with registered read data
module imhu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/indexed_min_heap_update.sv
// indexed min-heap update: top level with sift sequencer over two mirrored rams
// a bad request is answered from idle with no ram access; sifting up or down moves one heap
//   level per cycle while the output is not stalled, and the new entry is written in the
//   finish state.
// throughput: one word at a time; the next word is taken once the last result is registered.
// reset clears the sequencer and the output valid; heap storage is not cleared.
module indexed_min_heap_update
  import imhu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UP   = 4'b0010,
    ST_DN   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [POS_BITS-1:0]    slot_r, slot_nxt;
  logic [SIZE_BITS-1:0]   size_r, size_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic                   first_r, first_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  logic                   we;
  logic [POS_BITS-1:0]    waddr;
  entry_t                 wdata;
  logic                   re;
  logic [POS_BITS-1:0]    raddr_a, raddr_b;
  entry_t                 rdata_a, rdata_b;

  logic                   can_emit;
  logic                   accept;
  logic [SIZE_BITS-1:0]   size_eff;
  logic                   bad;
  logic [POS_BITS-1:0]    up_pos;
  logic [CHILD_BITS-1:0]  lc, rc;
  logic                   lc_ok, rc_ok, l_sel, r_sel;
  logic [POS_BITS-1:0]    best_pos;
  entry_t                 best_ent;

  imhu_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CAPACITY)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  // mirror copy gives the second read port for the right child
  imhu_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CAPACITY)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign can_emit  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && can_emit);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign size_eff = (in_word.heap_size > SIZE_BITS'(CAPACITY)) ? SIZE_BITS'(CAPACITY)
                                                               : in_word.heap_size;
  assign bad      = {1'b0, in_word.position} >= size_eff;

  // parent and children of the current slot; child indices sized to hold 2*slot+2
  assign up_pos = (slot_r - POS_BITS'(1)) >> 1;
  assign lc     = {1'b0, slot_r, 1'b1};
  assign rc     = {1'b0, slot_r, 1'b0} + CHILD_BITS'(2);
  assign lc_ok  = lc < CHILD_BITS'(size_r);
  assign rc_ok  = rc < CHILD_BITS'(size_r);
  assign l_sel  = lc_ok && (rdata_a.key < key_r);
  // left wins ties; compare right against whichever is currently best
  assign r_sel  = rc_ok && (l_sel ? (rdata_b.key < rdata_a.key) : (rdata_b.key < key_r));

  always_comb begin
    best_pos = slot_r;
    best_ent = rdata_a;
    if (r_sel) begin
      best_pos = rc[POS_BITS-1:0];
      best_ent = rdata_b;
    end else if (l_sel) begin
      best_pos = lc[POS_BITS-1:0];
      best_ent = rdata_a;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    size_nxt      = size_r;
    key_nxt       = key_r;
    handle_nxt    = handle_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    we            = 1'b0;
    waddr         = slot_r;
    wdata         = rdata_a;
    re            = 1'b0;
    raddr_a       = up_pos;
    raddr_b       = rc[POS_BITS-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_nxt   = in_word.position;
          size_nxt   = size_eff;
          key_nxt    = in_word.entry_key;
          handle_nxt = in_word.entry_handle;
          first_nxt  = 1'b1;
          if (bad) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{moved_handle: '0, new_position: '0,
                              last_move: 1'b1, bad_request: 1'b1};
          end else if (in_word.position != '0) begin
            re        = 1'b1;
            raddr_a   = (in_word.position - POS_BITS'(1)) >> 1;
            state_nxt = ST_UP;
          end else begin
            // root slot: go straight to sifting down
            re        = 1'b1;
            raddr_a   = POS_BITS'(1);
            raddr_b   = POS_BITS'(2);
            state_nxt = ST_DN;
          end
        end
      end

      ST_UP: begin
        if (rdata_a.key > key_r) begin
          if (can_emit) begin
            we            = 1'b1;
            waddr         = slot_r;
            wdata         = rdata_a;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{moved_handle: rdata_a.handle, new_position: slot_r,
                              last_move: 1'b0, bad_request: 1'b0};
            slot_nxt      = up_pos;
            first_nxt     = 1'b0;
            if (up_pos != '0) begin
              re      = 1'b1;
              raddr_a = (up_pos - POS_BITS'(1)) >> 1;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        end else if (first_r) begin
          // parent not larger on the first look: switch to sifting down
          re        = 1'b1;
          raddr_a   = lc[POS_BITS-1:0];
          raddr_b   = rc[POS_BITS-1:0];
          state_nxt = ST_DN;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_DN: begin
        if (best_pos == slot_r) begin
          state_nxt = ST_FIN;
        end else if (can_emit) begin
          we            = 1'b1;
          waddr         = slot_r;
          wdata         = best_ent;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{moved_handle: best_ent.handle, new_position: slot_r,
                            last_move: 1'b0, bad_request: 1'b0};
          slot_nxt      = best_pos;
          re            = 1'b1;
          raddr_a       = POS_BITS'({best_pos, 1'b1});
          raddr_b       = POS_BITS'({1'b0, best_pos, 1'b0} + (POS_BITS + 1)'(2));
        end
      end

      ST_FIN: begin
        if (can_emit) begin
          we            = 1'b1;
          waddr         = slot_r;
          wdata         = '{key: key_r, handle: handle_r};
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{moved_handle: handle_r, new_position: slot_r,
                            last_move: 1'b1, bad_request: 1'b0};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    size_r     <= size_nxt;
    key_r      <= key_nxt;
    handle_r   <= handle_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// File: tb/sv/tb_indexed_min_heap_update.sv
// self-checking testbench for the indexed min-heap update block
`timescale 1ns / 1ps

module tb_indexed_min_heap_update
  import imhu_pkg::*;
();

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_WORDS = 150;
  localparam int FILL_SLOTS = 300;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS = 18;
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t result;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_word_t out_word;

  // mirror of the heap arrays and the moves still to come out
  logic [KEY_BITS-1:0]    key_mirror [CAPACITY];
  logic [HANDLE_BITS-1:0] handle_mirror [CAPACITY];
  out_word_t              step_moves [$];
  out_word_t              pending_moves [$];

  int unsigned slots_written = 0;
  int unsigned words_sent = 0;
  int unsigned rejects_sent = 0;
  int unsigned oversize_sent = 0;
  int unsigned moves_checked = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          send_busy = 1'b1;
  bit          recv_busy = 1'b1;

  // directed words: bad positions, extremes, ties on the way up and down
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{10'd0,    11'd0,    64'd5,   16'h1234}, 1'b1, '{16'h0000, 10'd0, 1'b1, 1'b1}},
    '{'{10'd0,    11'd1,    KEY_MAX, 16'hffff}, 1'b1, '{16'hffff, 10'd0, 1'b1, 1'b0}},
    '{'{10'd1,    11'd1,    64'd7,   16'h0001}, 1'b1, '{16'h0000, 10'd0, 1'b1, 1'b1}},
    '{'{10'd1023, 11'd1023, 64'd0,   16'h0000}, 1'b1, '{16'h0000, 10'd0, 1'b1, 1'b1}},
    '{'{10'd1023, 11'd0,    KEY_MAX, 16'hffff}, 1'b1, '{16'h0000, 10'd0, 1'b1, 1'b1}},
    '{'{10'd1,    11'd2,    64'd0,   16'h0001}, 1'b0, '0},
    '{'{10'd2,    11'd3,    64'd0,   16'h0002}, 1'b0, '0},
    '{'{10'd0,    11'd3,    64'd5,   16'h0003}, 1'b0, '0},
    '{'{10'd0,    11'd3,    64'd0,   16'h0004}, 1'b0, '0},
    '{'{10'd3,    11'd4,    64'd7,   16'h0005}, 1'b0, '0},
    '{'{10'd0,    11'd4,    64'd9,   16'h0006}, 1'b0, '0},
    '{'{10'd1,    11'd4,    64'd5,   16'h0007}, 1'b0, '0},
    '{'{10'd2,    11'd4,    64'd5,   16'h0008}, 1'b0, '0},
    '{'{10'd0,    11'd4,    64'd6,   16'h0009}, 1'b0, '0},
    '{'{10'd0,    11'd4,    64'd5,   16'h000a}, 1'b0, '0},
    '{'{10'd4, 11'd5, 64'h8000_0000_0000_0000, 16'h8000}, 1'b0, '0},
    '{'{10'd0,    11'd1,    64'd3,   16'h000b}, 1'b1, '{16'h000b, 10'd0, 1'b1, 1'b0}},
    '{'{10'd2,    11'd2,    64'd0,   16'h0000}, 1'b1, '{16'h0000, 10'd0, 1'b1, 1'b1}}
  };

  indexed_min_heap_update i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d moves outstanding", cycle_count,
             pending_moves.size());
    $display("tb_indexed_min_heap_update failed");
    $finish;
  end

  task automatic note_mismatch(input string what);
    err_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // write the entry and restore heap order, collecting every slot move in step_moves
  task automatic predict_update(input in_word_t w);
    int unsigned slot, size, up, lc, rc, best;
    logic [KEY_BITS-1:0]    key, best_key;
    logic [HANDLE_BITS-1:0] hdl;
    step_moves.delete();
    slot = w.position;
    size = w.heap_size;
    key  = w.entry_key;
    hdl  = w.entry_handle;
    if (size > CAPACITY) begin
      size = CAPACITY;
    end
    if (slot >= size) begin
      step_moves.push_back(out_word_t'{16'h0, 10'd0, 1'b1, 1'b1});
      return;
    end
    if (slot > 0 && key_mirror[(slot - 1) / 2] > key) begin
      while (slot > 0) begin
        up = (slot - 1) / 2;
        if (!(key_mirror[up] > key)) break;
        key_mirror[slot]    = key_mirror[up];
        handle_mirror[slot] = handle_mirror[up];
        step_moves.push_back(out_word_t'{handle_mirror[slot], 10'(slot), 1'b0, 1'b0});
        slot = up;
      end
    end else begin
      forever begin
        lc = 2 * slot + 1;
        rc = lc + 1;
        best = slot;
        best_key = key;
        if (lc < size && key_mirror[lc] < best_key) begin
          best = lc;
          best_key = key_mirror[lc];
        end
        // right child only wins when strictly smaller, so ties go left
        if (rc < size && key_mirror[rc] < best_key) begin
          best = rc;
        end
        if (best == slot) break;
        key_mirror[slot]    = key_mirror[best];
        handle_mirror[slot] = handle_mirror[best];
        step_moves.push_back(out_word_t'{handle_mirror[slot], 10'(slot), 1'b0, 1'b0});
        slot = best;
      end
    end
    key_mirror[slot]    = key;
    handle_mirror[slot] = hdl;
    step_moves.push_back(out_word_t'{hdl, 10'(slot), 1'b1, 1'b0});
  endtask

  // offer one word, and once it is taken queue what it should produce
  task automatic offer_word(input in_word_t w, input logic typed, input out_word_t result);
    int unsigned gap;
    if (words_sent % 40 == 0) begin
      send_busy = $urandom_range(0, 1);
    end
    gap = send_busy ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_update(w);
    if (typed) begin
      pending_moves.push_back(result);
    end else begin
      foreach (step_moves[i]) pending_moves.push_back(step_moves[i]);
    end
    if (step_moves[0].bad_request) begin
      rejects_sent++;
    end else if (w.position == slots_written) begin
      slots_written++;
    end
    if (w.heap_size > CAPACITY) begin
      oversize_sent++;
    end
    words_sent++;
  endtask

  function automatic logic [KEY_BITS-1:0] draw_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return KEY_MAX;
      2:       return KEY_BITS'($urandom_range(0, 15));
      3:       return key_mirror[$urandom_range(0, slots_written - 1)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_moves.size() != 0) @(posedge clk);
  endtask

  initial begin : result_side
    out_word_t   got, want;
    int unsigned hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (moves_checked % 40 == 0) begin
        recv_busy = $urandom_range(0, 1);
      end
      hold = recv_busy ? $urandom_range(0, 6) : 0;
      // one long hold-off so the block backs up into its input
      if (moves_checked == HOLD_AT) begin
        hold = HOLD_CYCLES;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = out_word;
      moves_checked++;
      if (pending_moves.size() == 0) begin
        note_mismatch($sformatf("unexpected word: handle %h slot %0d last %b bad %b",
                                got.moved_handle, got.new_position, got.last_move,
                                got.bad_request));
      end else begin
        want = pending_moves.pop_front();
        if (got.moved_handle !== want.moved_handle) begin
          note_mismatch($sformatf("moved_handle %h, want %h", got.moved_handle,
                                  want.moved_handle));
        end
        if (got.new_position !== want.new_position) begin
          note_mismatch($sformatf("new_position %0d, want %0d", got.new_position,
                                  want.new_position));
        end
        if (got.last_move !== want.last_move) begin
          note_mismatch($sformatf("last_move %b, want %b", got.last_move, want.last_move));
        end
        if (got.bad_request !== want.bad_request) begin
          note_mismatch($sformatf("bad_request %b, want %b", got.bad_request,
                                  want.bad_request));
        end
      end
    end
  end

  initial begin : stimulus
    in_word_t    w;
    int unsigned pick, size;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);
    end
    in_valid <= 1'b0;
    wait_drained();

    // grow the heap to FILL_SLOTS entries by inserts at the end of the array
    while (slots_written < FILL_SLOTS) begin
      w = in_word_t'{10'(slots_written), 11'(slots_written + 1), draw_key(),
                     HANDLE_BITS'($urandom)};
      offer_word(w, 1'b0, '0);
    end

    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        size = $urandom_range(0, CAPACITY - 1);
        w.heap_size = 11'(size);
        w.position  = 10'($urandom_range(size, CAPACITY - 1));
      end else if (pick < 20) begin
        // slots without children inside the full array, whose parent is filled
        w.heap_size = 11'($urandom_range(CAPACITY, 2047));
        w.position  = 10'($urandom_range(CAPACITY / 2, 2 * FILL_SLOTS));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: size = $urandom_range(1, 32);
          5, 6, 7:       size = $urandom_range(1, FILL_SLOTS);
          default:       size = FILL_SLOTS;
        endcase
        w.heap_size = 11'(size);
        w.position  = 10'($urandom_range(0, size - 1));
      end
      w.entry_key    = draw_key();
      w.entry_handle = HANDLE_BITS'($urandom);
      offer_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("%0d heap updates sent (%0d rejected, %0d with oversized heap), %0d moves checked",
             words_sent, rejects_sent, oversize_sent, moves_checked);
    $display("heap filled to %0d slots, %0d mismatches", slots_written, err_count);
    if (err_count == 0 && pending_moves.size() == 0) begin
      $display("tb_indexed_min_heap_update passed");
    end else begin
      $display("tb_indexed_min_heap_update failed");
    end
    $finish;
  end

endmodule
